[sv/peak_hold_frequency_tracker_defines.svh]
// Assertion macros for the peak-hold frequency tracker.
// Needs nothing else; taken in by files that carry concurrent assertions.
`ifndef PEAK_HOLD_FREQUENCY_TRACKER_DEFINES_SVH
`define PEAK_HOLD_FREQUENCY_TRACKER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PHFT_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("phft: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PHFT_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("phft: assertion failed");

`endif

[sv/phft_pkg.sv]
// Package for the peak-hold frequency tracker: widths, reset values and result codes.
// Depends on nothing; used by peak_hold_frequency_tracker.
`default_nettype none

package phft_pkg;

    // Fraction bits of the frequency filter.
    localparam int FRAC_BITS = 8;

    localparam int FREQ_W   = 30;
    localparam int RSSI_W   = 9;
    localparam int HOLD_W   = 6;
    localparam int HZ_W     = 24;
    localparam int GAIN_W   = 9;
    localparam int FILT_W   = FREQ_W + FRAC_BITS;
    localparam int PROD_W   = FILT_W + GAIN_W;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    // Gain is in 1/256 units.
    localparam int GAIN_SHIFT = 8;
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_RELOAD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_HZ        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_OFFSET_HZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN      = 3'd5;

    // Reset values of the configuration registers.
    localparam logic signed [RSSI_W-1:0] THRESHOLD_RESET = -9'sd180;
    localparam logic [HOLD_W-1:0]        HOLD_RESET      = 6'd20;
    localparam logic [HZ_W-1:0]          JUMP_RESET      = 24'd500000;
    localparam logic [HZ_W-1:0]          OFFSET_RESET    = 24'd500000;
    localparam logic [GAIN_W-1:0]        FAST_GAIN_RESET = 9'd230;
    localparam logic [GAIN_W-1:0]        SLOW_GAIN_RESET = 9'd8;

    // Held peak strength after reset and after every sweep end.
    localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = -9'sd254;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_FINE_REQ = 2'd0,
        KIND_FOUND    = 2'd1,
        KIND_NONE     = 2'd2
    } kind_t;

endpackage

`default_nettype wire

[sv/peak_hold_frequency_tracker.sv]
// Peak-hold frequency tracker top level: input register, peak and filter logic, result register.
// Depends on phft_pkg and peak_hold_frequency_tracker_defines.svh.
//
//  Channel   Handshake                Payload
//  -------   ----------------------   ---------------------------------------------------
//  in        in_valid / in_stall      frequency_hz, rssi_half_db, sweep_end, fine_pass
//  out       out_valid / out_stall    kind, result_frequency_hz, result_rssi_half_db
//  cfg       cfg_write                cfg_index, cfg_data
//
// An item is held in the input register and its result, if any, is registered in the result
// register when the item leaves: one item per cycle sustained while no result is held stalled.
// The filter update is combinational (subtract, compare, 38 x 9 multiply, add).
// Reset clears all control and tracking state and loads the register defaults.
// An item that gives a result waits in the input register while a result is held stalled;
// items that give no result keep flowing.
`default_nettype none

`include "peak_hold_frequency_tracker_defines.svh"

module peak_hold_frequency_tracker
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic [phft_pkg::FREQ_W-1:0]         frequency_hz,
    input  wire logic signed [phft_pkg::RSSI_W-1:0]  rssi_half_db,
    input  wire logic                                sweep_end,
    input  wire logic                                fine_pass,

    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic [1:0]                          kind,
    output      logic [phft_pkg::FREQ_W-1:0]         result_frequency_hz,
    output      logic signed [phft_pkg::RSSI_W-1:0]  result_rssi_half_db,

    input  wire logic                                cfg_write,
    input  wire logic [phft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [phft_pkg::CFG_W-1:0]          cfg_data
);

    // Configuration registers.
    logic signed [phft_pkg::RSSI_W-1:0] threshold_reg;
    logic [phft_pkg::HOLD_W-1:0]        hold_reload_reg;
    logic [phft_pkg::HZ_W-1:0]          jump_reg;
    logic [phft_pkg::HZ_W-1:0]          offset_reg;
    logic [phft_pkg::GAIN_W-1:0]        fast_gain_reg;
    logic [phft_pkg::GAIN_W-1:0]        slow_gain_reg;

    // Input register.
    logic                               in_valid_reg;
    logic [phft_pkg::FREQ_W-1:0]        freq_in_reg;
    logic signed [phft_pkg::RSSI_W-1:0] rssi_in_reg;
    logic                               end_in_reg;
    logic                               fine_in_reg;

    // Tracking state.
    logic signed [phft_pkg::RSSI_W-1:0] best_rssi_reg;
    logic signed [phft_pkg::RSSI_W-1:0] best_rssi_next;
    logic [phft_pkg::FREQ_W-1:0]        best_freq_reg;
    logic [phft_pkg::FREQ_W-1:0]        best_freq_next;
    logic [phft_pkg::HOLD_W-1:0]        hold_left_reg;
    logic [phft_pkg::HOLD_W-1:0]        hold_left_next;
    logic [phft_pkg::FILT_W-1:0]        filt_reg;
    logic [phft_pkg::FILT_W-1:0]        filt_next;

    // Result register.
    logic                               out_valid_reg;
    phft_pkg::kind_t                    kind_reg;
    phft_pkg::kind_t                    kind_next;
    logic [phft_pkg::FREQ_W-1:0]        res_freq_reg;
    logic [phft_pkg::FREQ_W-1:0]        res_freq_next;
    logic signed [phft_pkg::RSSI_W-1:0] res_rssi_reg;
    logic signed [phft_pkg::RSSI_W-1:0] res_rssi_next;

    // Processing signals.
    logic                               in_take;
    logic                               advance;
    logic                               produce;
    logic                               above;
    logic signed [phft_pkg::RSSI_W-1:0] peak_rssi;
    logic [phft_pkg::FREQ_W-1:0]        peak_freq;
    logic [phft_pkg::FILT_W-1:0]        target;
    logic                               neg;
    logic [phft_pkg::FILT_W-1:0]        mag;
    logic [phft_pkg::FILT_W-1:0]        jump_ext;
    logic [phft_pkg::GAIN_W-1:0]        gain_raw;
    logic [phft_pkg::GAIN_W-1:0]        gain;
    logic [phft_pkg::PROD_W-1:0]        prod;
    logic [phft_pkg::PROD_W-1:0]        prod_round;
    logic [phft_pkg::FILT_W-1:0]        step;
    logic [phft_pkg::FILT_W-1:0]        filt_upd;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= phft_pkg::THRESHOLD_RESET;
            hold_reload_reg <= phft_pkg::HOLD_RESET;
            jump_reg        <= phft_pkg::JUMP_RESET;
            offset_reg      <= phft_pkg::OFFSET_RESET;
            fast_gain_reg   <= phft_pkg::FAST_GAIN_RESET;
            slow_gain_reg   <= phft_pkg::SLOW_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                phft_pkg::REG_RSSI_THRESHOLD:
                    threshold_reg <= signed'(cfg_data[phft_pkg::RSSI_W-1:0]);
                phft_pkg::REG_HOLD_RELOAD:
                    hold_reload_reg <= cfg_data[phft_pkg::HOLD_W-1:0];
                phft_pkg::REG_JUMP_HZ:
                    jump_reg <= cfg_data[phft_pkg::HZ_W-1:0];
                phft_pkg::REG_FINE_OFFSET_HZ:
                    offset_reg <= cfg_data[phft_pkg::HZ_W-1:0];
                phft_pkg::REG_FAST_GAIN:
                    fast_gain_reg <= cfg_data[phft_pkg::GAIN_W-1:0];
                phft_pkg::REG_SLOW_GAIN:
                    slow_gain_reg <= cfg_data[phft_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: an item leaves the input register unless its result meets a stalled one.
    assign advance  = !produce || !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            freq_in_reg <= frequency_hz;
            rssi_in_reg <= rssi_half_db;
            end_in_reg  <= sweep_end;
            fine_in_reg <= fine_pass;
        end
    end

    // Peak selection: the held peak is replaced only by a strictly stronger item.
    always_comb
    begin
        if (rssi_in_reg > best_rssi_reg)
        begin
            peak_rssi = rssi_in_reg;
            peak_freq = freq_in_reg;
        end
        else
        begin
            peak_rssi = best_rssi_reg;
            peak_freq = best_freq_reg;
        end
    end

    assign above = peak_rssi > threshold_reg;

    // Filter error term and gain choice.
    assign target   = {peak_freq, {phft_pkg::FRAC_BITS{1'b0}}};
    assign neg      = target < filt_reg;
    assign mag      = neg ? (filt_reg - target) : (target - filt_reg);
    assign jump_ext = phft_pkg::FILT_W'({jump_reg, {phft_pkg::FRAC_BITS{1'b0}}});
    assign gain_raw = (mag > jump_ext) ? fast_gain_reg : slow_gain_reg;
    assign gain     = (gain_raw > phft_pkg::GAIN_MAX) ? phft_pkg::GAIN_MAX : gain_raw;

    // Step is the floored product: a downward step rounds its magnitude up.
    assign prod       = phft_pkg::PROD_W'(mag) * phft_pkg::PROD_W'(gain);
    assign prod_round = neg ? (prod + phft_pkg::PROD_W'(255)) : prod;
    assign step       = prod_round[phft_pkg::GAIN_SHIFT +: phft_pkg::FILT_W];
    assign filt_upd   = (filt_reg == '0) ? target
                      : (neg ? (filt_reg - step) : (filt_reg + step));

    // Next state and result for the item in the input register.
    always_comb
    begin
        best_rssi_next = best_rssi_reg;
        best_freq_next = best_freq_reg;
        hold_left_next = hold_left_reg;
        filt_next      = filt_reg;
        produce        = 1'b0;
        kind_next      = phft_pkg::KIND_NONE;
        res_freq_next  = '0;
        res_rssi_next  = '0;

        if (in_valid_reg)
        begin
            if (!end_in_reg)
            begin
                best_rssi_next = peak_rssi;
                best_freq_next = peak_freq;
            end
            else
            begin
                best_rssi_next = phft_pkg::RSSI_FLOOR;
                best_freq_next = '0;
                priority if (!fine_in_reg && above)
                begin
                    // Coarse sweep found something: ask for a fine sweep below it.
                    produce       = 1'b1;
                    kind_next     = phft_pkg::KIND_FINE_REQ;
                    res_freq_next = (peak_freq > phft_pkg::FREQ_W'(offset_reg))
                                  ? (peak_freq - phft_pkg::FREQ_W'(offset_reg)) : '0;
                end
                else if (above)
                begin
                    produce        = 1'b1;
                    hold_left_next = hold_reload_reg;
                    filt_next      = filt_upd;
                    kind_next      = phft_pkg::KIND_FOUND;
                    res_freq_next  = filt_upd[phft_pkg::FRAC_BITS +: phft_pkg::FREQ_W];
                    res_rssi_next  = peak_rssi;
                end
                else if (hold_left_reg != '0)
                begin
                    hold_left_next = hold_left_reg - 1'b1;
                end
                else
                begin
                    produce   = 1'b1;
                    filt_next = '0;
                    kind_next = phft_pkg::KIND_NONE;
                end
            end
        end
    end

    // Tracking state moves only when the item leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_rssi_reg <= phft_pkg::RSSI_FLOOR;
            best_freq_reg <= '0;
            hold_left_reg <= '0;
            filt_reg      <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            best_rssi_reg <= best_rssi_next;
            best_freq_reg <= best_freq_next;
            hold_left_reg <= hold_left_next;
            filt_reg      <= filt_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_valid_reg && advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance && produce)
        begin
            kind_reg     <= kind_next;
            res_freq_reg <= res_freq_next;
            res_rssi_reg <= res_rssi_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign kind                = kind_reg;
    assign result_frequency_hz = res_freq_reg;
    assign result_rssi_half_db = res_rssi_reg;

    // The input side only waits behind a stalled result.
    `PHFT_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid_reg && out_stall)

    // Every sweep end that leaves the input register clears the held peak.
    `PHFT_ASSERT_NEXT(a_peak_cleared, clk, rst_n, in_valid_reg && advance && end_in_reg,
        best_rssi_reg == phft_pkg::RSSI_FLOOR && best_freq_reg == '0)

    // The filter returns to zero only together with a result that reports frequency zero,
    // either nothing found or a peak found at zero hertz.
    `PHFT_ASSERT_SAME(a_filter_clear, clk, rst_n, filt_reg == '0 && $past(filt_reg) != '0,
        out_valid_reg && res_freq_reg == '0)

endmodule

`default_nettype wire
